@@ hdl/hpt_pkg.sv @@
package hpt_pkg;

  localparam int CompW  = 16;
  localparam int ProdW  = 32;
  localparam int DotW   = 34;
  localparam int QuoW   = 16;
  localparam int NumRows = 4;
  localparam int RowW   = 64;
  localparam int AddrW  = 5;

  localparam logic signed [CompW-1:0] SatMax = 16'sh7fff;
  localparam logic signed [CompW-1:0] SatMin = -16'sh8000;

  typedef enum logic [1:0] {
    REG_ROW_0 = 2'd0,
    REG_ROW_1 = 2'd1,
    REG_ROW_2 = 2'd2,
    REG_ROW_3 = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic zero;
    logic clip;
  } div_flags_t;

endpackage

@@ hdl/homogeneous_point_transform.sv @@
// channel   | handshake           | payload
// ----------+---------------------+-----------------------------------
// point in  | start, busy         | in_x, in_y, in_z, in_w
// result    | done (one cycle)    | out_x, out_y, out_z, w_zero, clipped
// config    | apb psel/penable    | paddr, pwdata, prdata (64-bit rows)
//
// one word accepted every cycle; busy is always low
// path: the product and sum stages of the dot product lanes, then the divider
// lanes (magnitude, overflow, one quotient bit per stage, sign), then the merge register
// synchronous reset clears the valid pipeline and loads the identity matrix
// the receiver cannot stall: each result is shown for one cycle only
module homogeneous_point_transform
  import hpt_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CompW-1:0]  in_x,
  input  logic signed [CompW-1:0]  in_y,
  input  logic signed [CompW-1:0]  in_z,
  input  logic signed [CompW-1:0]  in_w,
  output logic                     done,
  output logic signed [CompW-1:0]  out_x,
  output logic signed [CompW-1:0]  out_y,
  output logic signed [CompW-1:0]  out_z,
  output logic                     w_zero,
  output logic                     clipped,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [RowW-1:0]          pwdata,
  output logic [RowW-1:0]          prdata,
  output logic                     pready
);

  localparam int Latency = 2 + QuoW + 3 + 1;
  localparam logic [RowW-1:0] One = RowW'(1) << FRACTION_BITS;

  // matrix rows
  logic [RowW-1:0] rows [0:NumRows-1];
  reg_idx_t        widx;
  logic            wr_en;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:3]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NumRows; r++) begin
        rows[r] <= One << (16 * r);
      end
    end else if (wr_en) begin
      case (widx)
        REG_ROW_0: rows[0] <= pwdata;
        REG_ROW_1: rows[1] <= pwdata;
        REG_ROW_2: rows[2] <= pwdata;
        REG_ROW_3: rows[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_ROW_0: prdata = rows[0];
      REG_ROW_1: prdata = rows[1];
      REG_ROW_2: prdata = rows[2];
      REG_ROW_3: prdata = rows[3];
      default:   prdata = '0;
    endcase
  end

  // every cycle may carry a word
  assign busy = 1'b0;

  // valid bits following the words through the lanes
  logic [Latency-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Latency-2:0], start & ~busy};
    end
  end
  assign done = vld[Latency-1];

  // four dot product lanes, one per matrix row
  logic signed [DotW-1:0] dot [0:NumRows-1];
  for (genvar r = 0; r < NumRows; r++) begin : g_dot
    hpt_dot u_dot (
      .clk (clk),
      .row (rows[r]),
      .vx  (in_x),
      .vy  (in_y),
      .vz  (in_z),
      .vw  (in_w),
      .dot (dot[r])
    );
  end

  // three divider lanes, each divides by the computed w
  logic signed [CompW-1:0] quo [0:2];
  div_flags_t              fl  [0:2];
  for (genvar r = 0; r < 3; r++) begin : g_div
    hpt_div #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
      .clk   (clk),
      .num   (dot[r]),
      .den   (dot[3]),
      .quo   (quo[r]),
      .flags (fl[r])
    );
  end

  // merge: gather the lane results, OR their clip flags and take w_zero from lane 0
  always_ff @(posedge clk) begin
    out_x   <= quo[0];
    out_y   <= quo[1];
    out_z   <= quo[2];
    w_zero  <= fl[0].zero;
    clipped <= fl[0].clip | fl[1].clip | fl[2].clip;
  end

endmodule

@@ hdl/hpt_dot.sv @@
module hpt_dot
  import hpt_pkg::*;
(
  input  logic                     clk,
  input  logic [RowW-1:0]          row,
  input  logic signed [CompW-1:0]  vx,
  input  logic signed [CompW-1:0]  vy,
  input  logic signed [CompW-1:0]  vz,
  input  logic signed [CompW-1:0]  vw,
  output logic signed [DotW-1:0]   dot
);

  logic signed [ProdW-1:0] prod [0:3];

  // stage 1: four products
  always_ff @(posedge clk) begin
    prod[0] <= $signed(row[15:0])  * vx;
    prod[1] <= $signed(row[31:16]) * vy;
    prod[2] <= $signed(row[47:32]) * vz;
    prod[3] <= $signed(row[63:48]) * vw;
  end

  // stage 2: sum
  always_ff @(posedge clk) begin
    dot <= DotW'(prod[0]) + DotW'(prod[1]) + DotW'(prod[2]) + DotW'(prod[3]);
  end

endmodule

@@ hdl/hpt_div.sv @@
module hpt_div
  import hpt_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic                    clk,
  input  logic signed [DotW-1:0]  num,
  input  logic signed [DotW-1:0]  den,
  output logic signed [CompW-1:0] quo,
  output div_flags_t              flags
);

  localparam int NumW = DotW + FRACTION_BITS;
  localparam int CmpW = NumW + QuoW + 1;

  // magnitude stage
  logic [NumW-1:0] a_num;
  logic [DotW-1:0] a_den;
  logic            a_neg;
  logic            a_zero;

  always_ff @(posedge clk) begin
    a_num  <= {(num[DotW-1] ? DotW'(-num) : DotW'(num)), {FRACTION_BITS{1'b0}}};
    a_den  <= den[DotW-1] ? DotW'(-den) : DotW'(den);
    a_neg  <= num[DotW-1] ^ den[DotW-1];
    a_zero <= (den == '0);
  end

  // overflow stage and iteration pipeline, index 0 is the overflow stage
  logic [NumW-1:0] rem  [0:QuoW];
  logic [QuoW-1:0] qb   [0:QuoW];
  logic [DotW-1:0] dv   [0:QuoW];
  logic            neg  [0:QuoW];
  logic            zr   [0:QuoW];
  logic            ovf  [0:QuoW];

  always_ff @(posedge clk) begin
    ovf[0] <= CmpW'(a_num) >= (CmpW'(a_den) << QuoW);
    rem[0] <= a_num;
    qb[0]  <= '0;
    dv[0]  <= a_den;
    neg[0] <= a_neg;
    zr[0]  <= a_zero;
  end

  for (genvar k = 1; k <= QuoW; k++) begin : g_step
    logic [CmpW-1:0] trial;
    logic            take;
    assign trial = CmpW'(dv[k-1]) << (QuoW - k);
    assign take  = CmpW'(rem[k-1]) >= trial;
    always_ff @(posedge clk) begin
      rem[k] <= take ? NumW'(CmpW'(rem[k-1]) - trial) : rem[k-1];
      qb[k]  <= qb[k-1] | (take ? (QuoW'(1) << (QuoW - k)) : '0);
      dv[k]  <= dv[k-1];
      neg[k] <= neg[k-1];
      zr[k]  <= zr[k-1];
      ovf[k] <= ovf[k-1];
    end
  end

  // sign and saturation
  logic [QuoW-1:0] q_fin;
  logic            clip_pos;
  logic            clip_neg;
  assign q_fin    = qb[QuoW];
  assign clip_pos = ovf[QuoW] | q_fin[QuoW-1];
  assign clip_neg = ovf[QuoW] | (q_fin[QuoW-1] & (q_fin[QuoW-2:0] != '0));

  always_ff @(posedge clk) begin
    if (zr[QuoW]) begin
      quo        <= '0;
      flags.clip <= 1'b0;
    end else if (neg[QuoW]) begin
      quo        <= clip_neg ? SatMin : CompW'(-q_fin);
      flags.clip <= clip_neg;
    end else begin
      quo        <= clip_pos ? SatMax : CompW'(q_fin);
      flags.clip <= clip_pos;
    end
    flags.zero <= zr[QuoW];
  end

endmodule

@@ hdl/hpt_check.sv @@
module hpt_check
  import hpt_pkg::*;
#(
  parameter int LATENCY = 22
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    done,
  input logic signed [CompW-1:0] out_x,
  input logic signed [CompW-1:0] out_y,
  input logic signed [CompW-1:0] out_z,
  input logic                    w_zero,
  input logic                    clipped
);

  // every accepted word gives a result after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted word gave no result");

  // no result without a word accepted earlier
  a_lat_back: assert property (@(posedge clk)
    (done && !$past(rst, LATENCY) && !$past(rst, 1)) |->
      $past(start && !busy, LATENCY))
    else $error("result without accepted word");

  // zero w gives zero outputs and no clipping
  a_wzero: assert property (@(posedge clk) disable iff (rst)
    (done && w_zero) |->
      (out_x == '0 && out_y == '0 && out_z == '0 && !clipped))
    else $error("zero w result not cleared");

  // a clipped result holds a saturated value somewhere
  a_clip: assert property (@(posedge clk) disable iff (rst)
    (done && clipped) |->
      (out_x == SatMax || out_x == SatMin || out_y == SatMax ||
       out_y == SatMin || out_z == SatMax || out_z == SatMin))
    else $error("clipped without saturated output");

endmodule

bind homogeneous_point_transform hpt_check #(
  .LATENCY (22)
) u_hpt_check (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .out_x   (out_x),
  .out_y   (out_y),
  .out_z   (out_z),
  .w_zero  (w_zero),
  .clipped (clipped)
);
